@@ rtl/core/mprf_pkg.sv @@
// ============================================================================
// mprf_pkg: shared types and constants of the mesh replay and route filter
// Verdict codes, back-end states and the front-to-back command word.
// ============================================================================
`default_nettype none

package mprf_pkg;

    localparam logic [7:0] HDR_VERSION  = 8'h01;
    localparam logic [7:0] PTYPE_MAV    = 8'h00;
    localparam int         WIN_BITS     = 32;
    localparam int         SEQ_BITS     = 16;
    localparam int         BUDGET_BITS  = 26;
    localparam logic [9:0] MS_TO_US     = 10'd1000;
    localparam int         ENTRY_BITS   = WIN_BITS + SEQ_BITS;

    typedef enum logic [3:0] {
        VERDICT_DELIVER = 4'd0,
        VERDICT_FORWARD = 4'd1,
        VERDICT_VERSION = 4'd2,
        VERDICT_NOSLOT  = 4'd3,
        VERDICT_DUP     = 4'd4,
        VERDICT_OLD     = 4'd5,
        VERDICT_STALE   = 4'd6,
        VERDICT_TTL     = 4'd7,
        VERDICT_TYPE    = 4'd8
    } t_verdict;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_bk_state;

    // check set: run the replay window, verdict applies only if it passes
    typedef struct packed {
        logic                check;
        t_verdict            verdict;
        logic [3:0]          slot;
        logic [SEQ_BITS-1:0] seq;
        logic [7:0]          fttl;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/core/mesh_packet_replay_and_route_filter_top.sv @@
// ============================================================================
// mesh_packet_replay_and_route_filter_top: mesh packet replay and route filter
// Gives one verdict word per received packet header word.
// ============================================================================
// Takes one packet header word and returns one verdict word (deliver,
// forward with decremented TTL, or a drop reason). The front end classifies
// version, slot, freshness, TTL, destination and type; the back end runs the
// per-peer 32-bit anti-replay window with a read then a write of the peer
// entry in RAM and takes a new word only once that read-modify-write is done.
// A word passes the front-end header register, the command queue, the back-end
// command register and the output register. The peer table is ready right
// after reset; unwritten entries read as empty through per-slot valid flags.
// Write own_system_id only while no word is in flight.
`default_nettype none

module mesh_packet_replay_and_route_filter_top
    import mprf_pkg::*;
#(
    parameter int PEER_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_header_version,
    input  wire logic        i_peer_slot_valid,
    input  wire logic [3:0]  i_peer_slot,
    input  wire logic [15:0] i_sequence_number,
    input  wire logic        i_no_time_sync,
    input  wire logic [63:0] i_origin_time_us,
    input  wire logic [15:0] i_deadline_ms,
    input  wire logic [63:0] i_now_us,
    input  wire logic [7:0]  i_time_to_live,
    input  wire logic [7:0]  i_destination_id,
    input  wire logic [7:0]  i_payload_type,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [3:0]  o_verdict,
    output      logic [7:0]  o_forward_ttl
);

    logic [7:0] r_own_id;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_cmd       push_cmd;
    t_cmd       head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= 8'd1;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_wdata;
        end
    end

    mprf_front #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_header_version  (i_header_version),
        .i_peer_slot_valid (i_peer_slot_valid),
        .i_peer_slot       (i_peer_slot),
        .i_sequence_number (i_sequence_number),
        .i_no_time_sync    (i_no_time_sync),
        .i_origin_time_us  (i_origin_time_us),
        .i_deadline_ms     (i_deadline_ms),
        .i_now_us          (i_now_us),
        .i_time_to_live    (i_time_to_live),
        .i_destination_id  (i_destination_id),
        .i_payload_type    (i_payload_type),
        .i_own_id          (r_own_id),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    mprf_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    mprf_back #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_cmd),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_verdict     (o_verdict),
        .o_forward_ttl (o_forward_ttl)
    );

endmodule

`default_nettype wire

@@ rtl/core/mprf_ram.sv @@
// ============================================================================
// mprf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module mprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/mprf_front.sv @@
// ============================================================================
// mprf_front: header intake and classification
// Register the header, check version, slot, freshness, TTL, destination and
// type, and push one command word per packet to the queue.
// ============================================================================
`default_nettype none

module mprf_front
    import mprf_pkg::*;
#(
    parameter int PEER_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_header_version,
    input  wire logic        i_peer_slot_valid,
    input  wire logic [3:0]  i_peer_slot,
    input  wire logic [15:0] i_sequence_number,
    input  wire logic        i_no_time_sync,
    input  wire logic [63:0] i_origin_time_us,
    input  wire logic [15:0] i_deadline_ms,
    input  wire logic [63:0] i_now_us,
    input  wire logic [7:0]  i_time_to_live,
    input  wire logic [7:0]  i_destination_id,
    input  wire logic [7:0]  i_payload_type,
    input  wire logic [7:0]  i_own_id,
    input  wire logic        i_q_full,
    output      logic        o_push,
    output      t_cmd        o_cmd
);

    logic                   r_s1_valid, n_s1_valid;
    logic                   r_s1_bad_ver;
    logic                   r_s1_no_slot;
    logic [3:0]             r_s1_slot;
    logic [15:0]            r_s1_seq;
    logic                   r_s1_nosync;
    logic                   r_s1_later;
    logic [63:0]            r_s1_diff;
    logic [BUDGET_BITS-1:0] r_s1_budget;
    logic [7:0]             r_s1_ttl;
    logic [7:0]             r_s1_dest;
    logic                   r_s1_ptype_nz;

    logic                   accept;
    logic [64:0]            diff_w;
    logic [BUDGET_BITS-1:0] budget_w;
    logic                   stale;
    t_verdict               post;
    logic [7:0]             fttl;

    assign o_in_stall = r_s1_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_valid && !i_q_full;

    assign diff_w   = {1'b0, i_now_us} - {1'b0, i_origin_time_us};
    assign budget_w = BUDGET_BITS'(i_deadline_ms) * BUDGET_BITS'(MS_TO_US);

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (o_push) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_bad_ver  <= (i_header_version != HDR_VERSION);
            r_s1_no_slot  <= !i_peer_slot_valid || ({5'b0, i_peer_slot} >= 9'(PEER_SLOTS));
            r_s1_slot     <= i_peer_slot;
            r_s1_seq      <= i_sequence_number;
            r_s1_nosync   <= i_no_time_sync;
            r_s1_later    <= !diff_w[64] && (diff_w[63:0] != 64'd0);
            r_s1_diff     <= diff_w[63:0];
            r_s1_budget   <= budget_w;
            r_s1_ttl      <= i_time_to_live;
            r_s1_dest     <= i_destination_id;
            r_s1_ptype_nz <= (i_payload_type != PTYPE_MAV);
        end
    end

    assign stale = !r_s1_nosync && r_s1_later &&
                   ((r_s1_diff[63:BUDGET_BITS] != '0) ||
                    (r_s1_diff[BUDGET_BITS-1:0] > r_s1_budget));

    always_comb begin
        fttl = 8'd0;
        if (stale) begin
            post = VERDICT_STALE;
        end else if (r_s1_ttl == 8'd0) begin
            post = VERDICT_TTL;
        end else if (r_s1_dest != i_own_id) begin
            post = VERDICT_FORWARD;
            fttl = r_s1_ttl - 8'd1;
        end else if (r_s1_ptype_nz) begin
            post = VERDICT_TYPE;
        end else begin
            post = VERDICT_DELIVER;
        end
    end

    always_comb begin
        o_cmd.slot = r_s1_slot;
        o_cmd.seq  = r_s1_seq;
        if (r_s1_bad_ver) begin
            o_cmd.check   = 1'b0;
            o_cmd.verdict = VERDICT_VERSION;
            o_cmd.fttl    = 8'd0;
        end else if (r_s1_no_slot) begin
            o_cmd.check   = 1'b0;
            o_cmd.verdict = VERDICT_NOSLOT;
            o_cmd.fttl    = 8'd0;
        end else begin
            o_cmd.check   = 1'b1;
            o_cmd.verdict = post;
            o_cmd.fttl    = fttl;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mprf_queue.sv @@
// ============================================================================
// mprf_queue: short command queue between front and back
// Small register FIFO of command words.
// ============================================================================
`default_nettype none

module mprf_queue
    import mprf_pkg::*;
#(
    parameter int DEPTH = 2,
    localparam int PW   = $clog2(DEPTH)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output      logic o_full,
    input  wire logic i_pop,
    output      t_cmd o_data,
    output      logic o_empty
);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [PW:0]   r_count, n_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mprf_back.sv @@
// ============================================================================
// mprf_back: replay window and verdict output
// Read the peer entry, update the sliding window, write it back if the check
// passes, and load the verdict into the output register.
// ============================================================================
`default_nettype none

module mprf_back
    import mprf_pkg::*;
#(
    parameter int PEER_SLOTS = 16,
    localparam int AW        = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_head,
    input  wire logic       i_empty,
    output      logic       o_pop,
    output      logic       o_out_valid,
    input  wire logic       i_out_stall,
    output      logic [3:0] o_verdict,
    output      logic [7:0] o_forward_ttl
);

    t_bk_state               r_state, n_state;
    t_cmd                    r_cmd;
    logic [AW-1:0]           r_idx;
    logic [PEER_SLOTS-1:0]   r_seen;
    logic                    r_out_valid;
    t_verdict                r_out_verdict;
    logic [7:0]              r_out_fttl;

    logic [8:0]              head_ext;
    logic [AW-1:0]           head_idx;
    logic [ENTRY_BITS-1:0]   rdata;
    logic                    go;
    logic [WIN_BITS-1:0]     win;
    logic [SEQ_BITS-1:0]     newest;
    logic [SEQ_BITS-1:0]     d;
    logic [SEQ_BITS-1:0]     back_d;
    logic                    rep_pass;
    logic                    rep_we;
    t_verdict                rep_verdict;
    logic [WIN_BITS-1:0]     wr_win;
    logic [SEQ_BITS-1:0]     wr_newest;
    logic                    ram_we;
    t_verdict                res_verdict;
    logic [7:0]              res_fttl;

    assign head_ext = {5'b0, i_head.slot};
    assign head_idx = head_ext[AW-1:0];

    mprf_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (PEER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({wr_win, wr_newest}),
        .i_re    (o_pop),
        .i_raddr (head_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        go    = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_empty;
            BK_EXEC: go    = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign win    = r_seen[r_idx] ? rdata[ENTRY_BITS-1:SEQ_BITS] : '0;
    assign newest = rdata[SEQ_BITS-1:0];
    assign d      = r_cmd.seq - newest;
    assign back_d = SEQ_BITS'(0) - d;

    always_comb begin
        rep_pass    = 1'b1;
        rep_we      = 1'b1;
        rep_verdict = VERDICT_DELIVER;
        wr_win      = 32'd1;
        wr_newest   = r_cmd.seq;
        if (win == '0) begin
            wr_win = 32'd1;
        end else if (d == '0) begin
            rep_pass    = 1'b0;
            rep_we      = 1'b0;
            rep_verdict = VERDICT_DUP;
        end else if (d[15:5] == '0) begin
            wr_win = (win << d[4:0]) | 32'd1;
        end else if (!d[15]) begin
            wr_win = 32'd1;
        end else if (back_d[15:5] != '0) begin
            rep_pass    = 1'b0;
            rep_we      = 1'b0;
            rep_verdict = VERDICT_OLD;
        end else if (win[back_d[4:0]]) begin
            rep_pass    = 1'b0;
            rep_we      = 1'b0;
            rep_verdict = VERDICT_DUP;
        end else begin
            wr_win    = win | (32'd1 << back_d[4:0]);
            wr_newest = newest;
        end
    end

    assign ram_we = go && r_cmd.check && rep_we;

    always_comb begin
        if (!r_cmd.check) begin
            res_verdict = r_cmd.verdict;
            res_fttl    = 8'd0;
        end else if (rep_pass) begin
            res_verdict = r_cmd.verdict;
            res_fttl    = r_cmd.fttl;
        end else begin
            res_verdict = rep_verdict;
            res_fttl    = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_seen[r_idx] <= 1'b1;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
            r_idx <= head_idx;
        end
        if (go) begin
            r_out_verdict <= res_verdict;
            r_out_fttl    <= res_fttl;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_out_verdict;
    assign o_forward_ttl = r_out_fttl;

endmodule

`default_nettype wire

@@ rtl/core/mprf_checker.sv @@
// ============================================================================
// mprf_checker: port-level checks of the replay and route filter
// Output word hold under stall and verdict/TTL consistency.
// ============================================================================
`default_nettype none

module mprf_checker
    import mprf_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [3:0] o_verdict,
    input wire logic [7:0] o_forward_ttl
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_verdict) && $stable(o_forward_ttl))
        else $error("output word changed while stalled");

    a_ttl_only_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict != VERDICT_FORWARD) |-> o_forward_ttl == 8'd0)
        else $error("forward_ttl set on a non-forward verdict");

    a_fwd_ttl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == VERDICT_FORWARD) |-> o_forward_ttl != 8'hFF)
        else $error("forward_ttl out of range");

endmodule

bind mesh_packet_replay_and_route_filter_top mprf_checker u_mprf_checker (.*);

`default_nettype wire
